// ===== rtl/mcpe_pkg.sv =====
package mcpe_pkg;

  localparam int W = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  localparam logic [2:0] REG_ORDER = 3'd0;
  localparam logic [2:0] REG_MODE  = 3'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // saturate a 64-bit value to 32 bits, flag overflow
  function automatic logic [32:0] sat64(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -64'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ===== rtl/mcpe_div.sv =====
// restoring divider: 64-bit magnitude / 33-bit magnitude, one quotient bit per cycle
module mcpe_div
  import mcpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [63:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] nmag_r, q_r;
  logic [33:0] rem_r;
  logic [32:0] dmag_r;
  logic        neg_r, busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [33:0] trial;
  logic [33:0] shifted;

  assign shifted = {rem_r[32:0], nmag_r[63]};
  assign trial   = shifted - {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
        nmag_r <= num[63] ? 64'(-num) : 64'(num);
        dmag_r <= den[32] ? 33'(-den) : 33'(den);
        neg_r  <= num[63] ^ den[32];
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        nmag_r <= {nmag_r[62:0], 1'b0};
        if (!trial[33]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? 64'(-q_r) : 64'(q_r);
endmodule

// ===== rtl/mcpe_lane.sv =====
// one lane per dimension: rescale then basis build into a local store
module mcpe_lane
  import mcpe_pkg::*;
#(
  parameter int MAX_ORDER = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic                         cheb,
  input  logic [3:0]                   nord,
  input  logic signed [31:0]           coord,
  input  logic signed [31:0]           lower,
  input  logic signed [31:0]           upper,
  input  logic [$clog2(MAX_ORDER+1)-1:0] rd_idx,
  output logic signed [31:0]           rd_data,
  output logic                         done,
  output logic                         ovf
);
  localparam int NB = MAX_ORDER + 1;
  localparam int IW = $clog2(NB);

  logic signed [31:0] basis_r [NB];
  logic signed [31:0] xr_r;
  logic               ovf_r, run_r, done_r;
  logic [3:0]         n_r;
  logic               dv_done;
  logic signed [63:0] quo;
  logic signed [63:0] num;
  logic signed [32:0] den;
  logic signed [63:0] prod;
  logic signed [63:0] w;
  logic [32:0]        xs, vs;
  logic signed [31:0] prev, prev2;

  assign num = 64'($signed(33'(coord) - 33'(lower))) <<< 17;
  assign den = 33'(upper) - 33'(lower);

  mcpe_div u_div (
    .clk(clk), .rst_n(rst_n), .go(go), .num(num), .den(den),
    .done(dv_done), .quo(quo)
  );

  assign xs    = sat64(quo - 64'sd65536);
  assign prev  = basis_r[IW'(n_r - 4'd1)];
  assign prev2 = basis_r[IW'(n_r - 4'd2)];
  assign prod  = 64'(xr_r) * 64'(prev);

  always_comb begin
    if (cheb && n_r >= 4'd2) w = (prod >>> 15) - 64'(prev2);
    else if (cheb) w = 64'(xr_r);
    else w = prod >>> 16;
    vs = sat64(w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) ovf_r <= 1'b0;
      if (dv_done) begin
        xr_r       <= xs[31:0];
        ovf_r      <= xs[32];
        basis_r[0] <= 32'sd65536;
        n_r        <= 4'd1;
        if (nord == 4'd0) done_r <= 1'b1;
        else run_r <= 1'b1;
      end else if (run_r) begin
        basis_r[IW'(n_r)] <= vs[31:0];
        if (vs[32]) ovf_r <= 1'b1;
        n_r <= n_r + 4'd1;
        if (n_r == nord) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rd_data = basis_r[rd_idx];
  assign done    = done_r;
  assign ovf     = ovf_r;
endmodule

// ===== rtl/mcpe_merge.sv =====
// merge stage: walks multi-indices, multiplies lane basis values and coefficient, accumulates
module mcpe_merge
  import mcpe_pkg::*;
#(
  parameter int MAX_ORDER = 7,
  parameter int MAX_TERMS = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [3:0]                     nord,
  output logic [$clog2(MAX_ORDER+1)-1:0] idx0,
  output logic [$clog2(MAX_ORDER+1)-1:0] idx1,
  output logic [$clog2(MAX_ORDER+1)-1:0] idx2,
  input  logic signed [31:0]             b0,
  input  logic signed [31:0]             b1,
  input  logic signed [31:0]             b2,
  output logic [$clog2(MAX_TERMS)-1:0]   caddr,
  input  logic signed [31:0]             cdata,
  output logic                           done,
  output logic signed [31:0]             acc,
  output logic                           ovf
);
  localparam int IW = $clog2(MAX_ORDER + 1);
  localparam int TW = $clog2(MAX_TERMS);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_M1, S_M2, S_M3, S_ACC} mstate_t;
  mstate_t st_r;

  logic [3:0] i0_r, i1_r, i2_r;
  logic [TW:0] t_r;
  logic signed [31:0] p_r, acc_r;
  logic ovf_r, done_r, last_r;
  logic signed [63:0] mop;
  logic signed [31:0] ma, mb;
  logic [32:0] ms, as;
  logic [5:0] sum;

  always_comb begin
    ma = p_r;
    mb = b1;
    unique case (st_r)
      S_M1:    begin ma = b0;  mb = b1; end
      S_M2:    begin ma = p_r; mb = b2; end
      S_M3:    begin ma = cdata; mb = p_r; end
      default: begin ma = p_r; mb = b1; end
    endcase
    mop = 64'(ma) * 64'(mb);
    ms  = sat64(mop >>> 16);
    as  = sat64(64'(acc_r) + 64'(p_r));
  end

  assign sum = 6'(i0_r) + 6'(i1_r) + 6'(i2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (go) begin
          i0_r <= '0; i1_r <= '0; i2_r <= '0;
          t_r <= '0; acc_r <= '0; ovf_r <= 1'b0;
          st_r <= S_RD;
        end
        S_RD: st_r <= S_M1;
        S_M1: begin
          p_r <= ms[31:0]; if (ms[32]) ovf_r <= 1'b1; st_r <= S_M2;
        end
        S_M2: begin
          p_r <= ms[31:0]; if (ms[32]) ovf_r <= 1'b1; st_r <= S_M3;
        end
        S_M3: begin
          p_r <= ms[31:0]; if (ms[32]) ovf_r <= 1'b1; st_r <= S_ACC;
          last_r <= (i0_r >= nord) || (t_r == (TW+1)'(MAX_TERMS - 1));
          // advance multi-index, last dimension fastest
          if (6'(sum) < 6'(nord)) i2_r <= i2_r + 4'd1;
          else if (6'(i0_r) + 6'(i1_r) + 6'd1 <= 6'(nord)) begin
            i2_r <= '0; i1_r <= i1_r + 4'd1;
          end else begin
            i2_r <= '0; i1_r <= '0; i0_r <= i0_r + 4'd1;
          end
          t_r <= t_r + 1'b1;
        end
        S_ACC: begin
          acc_r <= as[31:0]; if (as[32]) ovf_r <= 1'b1;
          if (last_r) begin
            done_r <= 1'b1; st_r <= S_IDLE;
          end else st_r <= S_RD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign idx0  = IW'(i0_r);
  assign idx1  = IW'(i1_r);
  assign idx2  = IW'(i2_r);
  assign caddr = TW'(t_r);
  assign done  = done_r;
  assign acc   = acc_r;
  assign ovf   = ovf_r;
endmodule

// ===== rtl/multivariate_chebyshev_poly_eval_core.sv =====
// channel   direction  handshake           payload
// in_       input      start & !busy       in_opcode, in_coeff_index, in_coeff_value, in_coord_*
// out_      output     out_valid (1 cycle) out_approx_value, out_status
// cfg_      input      apb write           order, chebyshev_mode, lower/upper bounds
// a write beat never raises busy. an evaluate runs the three lane dividers side by side
// (64 quotient bits), then the basis steps up to the order, then per term a read, the
// multiplies in the shared merge multiplier and an accumulate; busy drops as the result
// shows, and an evaluate at order 7 walks 120 terms.
// an empty range answers in the cycle after accept and never raises busy. synchronous
// active-low reset clears control state; the coefficient table is not cleared.
// results cannot be stalled.
module multivariate_chebyshev_poly_eval_core
  import mcpe_pkg::*;
#(
  parameter int MAX_ORDER = 7,
  parameter int MAX_TERMS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [6:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_coord_0,
  input  logic signed [31:0] in_coord_1,
  input  logic signed [31:0] in_coord_2,
  output logic               out_valid,
  output logic signed [31:0] out_approx_value,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int IW = $clog2(MAX_ORDER + 1);
  localparam int TW = $clog2(MAX_TERMS);

  typedef enum logic [1:0] {T_IDLE, T_BASIS, T_WALK} tstate_t;
  tstate_t st_r;

  logic [2:0]         order_r;
  logic               mode_r;
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic signed [31:0] coef_mem [MAX_TERMS];
  logic signed [31:0] cdata_r;
  logic signed [31:0] res_r;
  logic [1:0]         stat_r;
  logic               oval_r, lovf_r;
  logic [2:0]         ldone_r;
  logic [3:0]         nord;
  logic               acc_in, go_lane, go_merge, empty;
  logic [2:0]         ldone, lovf;
  logic [IW-1:0]      ix [3];
  logic signed [31:0] bv [3];
  logic [TW-1:0]      caddr;
  logic               mdone, movf;
  logic signed [31:0] macc;
  logic [2:0]         ra;

  assign pready = 1'b1;
  assign ra     = paddr[4:2];
  assign nord   = (4'(order_r) > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : 4'(order_r);
  assign acc_in = start && !busy;
  assign empty  = (lo_r[0] == hi_r[0]) || (lo_r[1] == hi_r[1]) || (lo_r[2] == hi_r[2]);
  assign busy   = (st_r != T_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd1;
      mode_r  <= 1'b0;
      for (int d = 0; d < 3; d++) begin
        lo_r[d] <= -32'sd65536;
        hi_r[d] <= 32'sd65536;
      end
    end else if (psel && penable && pwrite) begin
      if (ra == REG_ORDER) order_r <= pwdata[2:0];
      else if (ra == REG_MODE) mode_r <= pwdata[0];
      else if (ra[0] == 1'b0) lo_r[2'(ra[2:1] - 2'd1)] <= pwdata;
      else hi_r[2'(ra[2:1] - 2'd1)] <= pwdata;
    end
  end

  always_comb begin
    unique case (ra)
      REG_ORDER: prdata = {29'd0, order_r};
      REG_MODE:  prdata = {31'd0, mode_r};
      default:   prdata = ra[0] ? hi_r[2'(ra[2:1] - 2'd1)] : lo_r[2'(ra[2:1] - 2'd1)];
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_in && in_opcode == OP_WRITE && 32'(in_coeff_index) < 32'(MAX_TERMS))
      coef_mem[TW'(in_coeff_index)] <= in_coeff_value;
    cdata_r <= coef_mem[caddr];
  end

  assign go_lane = acc_in && in_opcode == OP_EVAL && !empty;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      mcpe_lane #(.MAX_ORDER(MAX_ORDER)) u_lane (
        .clk(clk), .rst_n(rst_n), .go(go_lane), .cheb(mode_r), .nord(nord),
        .coord(g == 0 ? in_coord_0 : (g == 1 ? in_coord_1 : in_coord_2)),
        .lower(lo_r[g]), .upper(hi_r[g]), .rd_idx(ix[g]), .rd_data(bv[g]),
        .done(ldone[g]), .ovf(lovf[g])
      );
    end
  endgenerate

  assign go_merge = (st_r == T_BASIS) && ((ldone_r | ldone) == 3'b111);

  mcpe_merge #(.MAX_ORDER(MAX_ORDER), .MAX_TERMS(MAX_TERMS)) u_merge (
    .clk(clk), .rst_n(rst_n), .go(go_merge), .nord(nord),
    .idx0(ix[0]), .idx1(ix[1]), .idx2(ix[2]), .b0(bv[0]), .b1(bv[1]), .b2(bv[2]),
    .caddr(caddr), .cdata(cdata_r), .done(mdone), .acc(macc), .ovf(movf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= T_IDLE;
      oval_r  <= 1'b0;
      ldone_r <= '0;
    end else begin
      oval_r <= 1'b0;
      unique case (st_r)
        T_IDLE: if (acc_in && in_opcode == OP_EVAL) begin
          if (empty) begin
            oval_r <= 1'b1; res_r <= '0; stat_r <= ST_EMPTY;
          end else begin
            st_r <= T_BASIS; ldone_r <= '0;
          end
        end
        T_BASIS: begin
          ldone_r <= ldone_r | ldone;
          if (go_merge) begin
            lovf_r <= |lovf;
            st_r   <= T_WALK;
          end
        end
        T_WALK: if (mdone) begin
          oval_r <= 1'b1;
          res_r  <= macc;
          stat_r <= (movf || lovf_r) ? ST_SAT : ST_OK;
          st_r   <= T_IDLE;
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid        = oval_r;
  assign out_approx_value = res_r;
  assign out_status       = stat_r;
endmodule

// ===== verif/tb_multivariate_chebyshev_poly_eval_core.sv =====
module tb_multivariate_chebyshev_poly_eval_core
  import mcpe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXO = 7;
  localparam int NTERMS = 128;

  typedef struct packed {
    logic        opcode;
    logic [6:0]  cidx;
    logic [31:0] cval;
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
  } beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [6:0] in_coeff_index = '0;
  logic signed [31:0] in_coeff_value = '0;
  logic signed [31:0] in_coord_0 = '0;
  logic signed [31:0] in_coord_1 = '0;
  logic signed [31:0] in_coord_2 = '0;
  logic out_valid;
  logic signed [31:0] out_approx_value;
  logic [1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multivariate_chebyshev_poly_eval_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_coeff_index(in_coeff_index),
    .in_coeff_value(in_coeff_value), .in_coord_0(in_coord_0),
    .in_coord_1(in_coord_1), .in_coord_2(in_coord_2),
    .out_valid(out_valid), .out_approx_value(out_approx_value),
    .out_status(out_status), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] coef_tbl [NTERMS];
  logic [2:0]         p_order;
  logic               p_cheb;
  logic signed [31:0] p_lo [3];
  logic signed [31:0] p_hi [3];

  beat_t   pending_beats[$];
  answer_t expected_answers[$];
  int      errors = 0;
  bit      idle_enable = 1'b1;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              inout bit ov);
    logic signed [127:0] pr;
    pr = 128'(a) * 128'(b);
    return clamp32(pr >>> 16, ov);
  endfunction

  function automatic answer_t evaluate_point(input beat_t b);
    answer_t r;
    bit ov;
    logic signed [31:0] basis [MAXO+1][3];
    logic signed [31:0] xs [3];
    logic signed [127:0] diff, span, q, w;
    logic signed [31:0] xr, p, acc;
    int idx [3];
    int nord, s, k;
    ov = 1'b0;
    xs[0] = b.x0;
    xs[1] = b.x1;
    xs[2] = b.x2;
    for (int d = 0; d < 3; d++) begin
      if (p_lo[d] == p_hi[d]) begin
        r.value = '0;
        r.status = ST_EMPTY;
        return r;
      end
    end
    nord = p_order;
    for (int d = 0; d < 3; d++) begin
      diff = 128'(xs[d]) - 128'(p_lo[d]);
      span = 128'(p_hi[d]) - 128'(p_lo[d]);
      // signed division truncates toward zero
      q = (diff * 128'sd131072) / span;
      xr = clamp32(q - 128'sd65536, ov);
      basis[0][d] = 32'sd65536;
      for (int n = 1; n <= nord; n++) begin
        if (p_cheb && n >= 2) begin
          w = ((128'(xr) * 128'(basis[n-1][d])) >>> 15) - 128'(basis[n-2][d]);
          basis[n][d] = clamp32(w, ov);
        end else if (p_cheb) begin
          basis[n][d] = xr;
        end else begin
          basis[n][d] = qmul(basis[n-1][d], xr, ov);
        end
      end
    end
    idx = '{0, 0, 0};
    acc = '0;
    for (int t = 0; t < NTERMS; t++) begin
      p = basis[idx[0]][0];
      for (int d = 1; d < 3; d++) p = qmul(p, basis[idx[d]][d], ov);
      p = qmul(coef_tbl[t], p, ov);
      acc = clamp32(128'(acc) + 128'(p), ov);
      if (idx[0] >= nord) break;
      if (idx[0] + idx[1] + idx[2] < nord) begin
        idx[2]++;
      end else begin
        k = 2;
        while (k > 0) begin
          idx[k] = 0;
          idx[k-1]++;
          s = idx[0] + idx[1] + idx[2];
          if (s <= nord) break;
          k--;
        end
      end
    end
    r.value = acc;
    r.status = ov ? ST_SAT : ST_OK;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    beat_t b;
    if (rst_n) begin
      if (start && !busy) begin
        b = pending_beats.pop_front();
        if (b.opcode == OP_WRITE) begin
          coef_tbl[b.cidx] <= b.cval;
        end else begin
          expected_answers.push_back(evaluate_point(b));
        end
      end
      // the accepted beat is already popped, so the next one is at the front
      if ((!start || !busy) && pending_beats.size() > 0
          && (!idle_enable || $urandom_range(99) >= 37)) begin
        b = pending_beats[0];
        start <= 1'b1;
        in_opcode <= b.opcode;
        in_coeff_index <= b.cidx;
        in_coeff_value <= b.cval;
        in_coord_0 <= b.x0;
        in_coord_1 <= b.x1;
        in_coord_2 <= b.x2;
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result value=%h status=%0d", out_approx_value, out_status);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (out_approx_value !== e.value) begin
          $error("approx_value expected %h actual %h", e.value, out_approx_value);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ORDER: p_order = val[2:0];
      REG_MODE:  p_cheb = val[0];
      default: begin
        if (idx % 2 == 0) p_lo[(idx - 2) / 2] = val;
        else p_hi[(idx - 2) / 2] = val;
      end
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || start || busy || expected_answers.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h80000000 ^ $urandom_range(1);
      2: return 32'h7fffffff - $urandom_range(1);
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(3) == 0) return $urandom();
    return 32'($signed($urandom_range(131072)) - 65536);
  endfunction

  task automatic push_eval(input logic [31:0] a, input logic [31:0] b2,
                           input logic [31:0] c);
    beat_t b;
    b = '{OP_EVAL, 7'($urandom()), $urandom(), a, b2, c};
    pending_beats.push_back(b);
  endtask

  task automatic push_write(input int i, input logic [31:0] v);
    beat_t b;
    b = '{OP_WRITE, 7'(i), v, $urandom(), $urandom(), $urandom()};
    pending_beats.push_back(b);
  endtask

  task automatic fill_table();
    for (int i = 0; i < NTERMS; i++) push_write(i, rand_coef());
  endtask

  task automatic set_bounds(input int kind);
    for (int d = 0; d < 3; d++) begin
      case (kind)
        0: begin
          write_reg(2 + 2 * d, 32'hffff0000);
          write_reg(3 + 2 * d, 32'h00010000);
        end
        1: begin
          write_reg(2 + 2 * d, 32'h80000000);
          write_reg(3 + 2 * d, 32'h7fffffff);
        end
        2: begin
          // reversed range
          write_reg(2 + 2 * d, 32'h00020000);
          write_reg(3 + 2 * d, 32'hfffe0000);
        end
        default: begin
          write_reg(2 + 2 * d, 32'($signed($urandom_range(65536)) - 98304));
          write_reg(3 + 2 * d, 32'($signed($urandom_range(65536)) + 32768));
        end
      endcase
    end
  endtask

  initial begin
    p_order = 3'd1;
    p_cheb = 1'b0;
    for (int d = 0; d < 3; d++) begin
      p_lo[d] = 32'hffff0000;
      p_hi[d] = 32'h00010000;
    end
    for (int i = 0; i < NTERMS; i++) coef_tbl[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table fill incl. extremes, then reset-config evaluates
    fill_table();
    push_write(0, 32'h7fffffff);
    push_write(1, 32'h80000000);
    push_eval(32'h0, 32'h0, 32'h0);
    push_eval(32'h7fffffff, 32'h80000000, 32'h00010000);
    push_eval(32'hffffffff, 32'h7fffffff, 32'h80000000);
    push_eval(32'h00008000, 32'hffff8000, 32'h00000001);
    drain();

    // order zero, chebyshev, order extremes
    write_reg(REG_ORDER, 32'd0);
    write_reg(REG_MODE, 32'd1);
    push_eval(32'h00004000, 32'h0, 32'h0);
    drain();
    write_reg(REG_ORDER, 32'd7);
    push_eval(32'h00004000, 32'hffffc000, 32'h00010000);
    push_eval(32'h7fffffff, 32'h80000000, 32'h0);
    drain();
    set_bounds(1);
    push_eval(32'h7fffffff, 32'h80000000, 32'h0);
    drain();
    set_bounds(2);
    push_eval(32'h00010000, 32'h0, 32'hffff0000);
    drain();
    // empty range in one dimension
    write_reg(4, 32'h00030000);
    write_reg(5, 32'h00030000);
    push_eval(32'h0, 32'h0, 32'h0);
    push_eval($urandom(), $urandom(), $urandom());
    drain();
    // write index extreme
    push_write(127, 32'hffffffff);
    push_write(127, 32'h0);

    for (int phase = 0; phase < 12; phase++) begin
      drain();
      idle_enable = (phase != 5);
      write_reg(REG_ORDER, (phase < 2) ? 32'd7 : 32'($urandom_range(7)));
      write_reg(REG_MODE, 32'($urandom_range(1)));
      set_bounds(phase % 4 == 3 ? $urandom_range(2) : 3);
      if (phase == 9) begin
        write_reg(6, 32'h0);
        write_reg(7, 32'h0);
      end
      for (int i = 0; i < 38; i++) begin
        if ($urandom_range(4) == 0) push_write($urandom_range(NTERMS - 1), rand_coef());
        else push_eval(rand_coord(), rand_coord(), rand_coord());
      end
    end
    drain();
    if (errors == 0) begin
      $display("multivariate_chebyshev_poly_eval_core test passed");
    end else begin
      $display("multivariate_chebyshev_poly_eval_core test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("multivariate_chebyshev_poly_eval_core test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mcpe_pkg.sv
rtl/mcpe_div.sv
rtl/mcpe_lane.sv
rtl/mcpe_merge.sv
rtl/multivariate_chebyshev_poly_eval_core.sv
verif/tb_multivariate_chebyshev_poly_eval_core.sv
